[rtl/capability_handle_table_assert.svh]
// assertion macros used by the rtl of the handle table
`ifndef CAPABILITY_HANDLE_TABLE_ASSERT_SVH
`define CAPABILITY_HANDLE_TABLE_ASSERT_SVH

`ifndef SYNTH
// property holds on every clock edge out of reset
`define CHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// trigger implies consequence in the next cycle
`define CHT_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define CHT_ASSERT(lbl, prop, msg)
`define CHT_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

[rtl/cht_pkg.sv]
package cht_pkg;

    typedef enum logic [3:0] {
        OP_CREATE    = 4'd0,
        OP_RETAIN    = 4'd1,
        OP_RELEASE   = 4'd2,
        OP_OPEN      = 4'd3,
        OP_GET       = 4'd4,
        OP_CLOSE     = 4'd5,
        OP_DUPLICATE = 4'd6,
        OP_REVOKE    = 4'd7,
        OP_CLOSE_ALL = 4'd8
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TASK  = 3'd1;
    localparam logic [2:0] ST_BAD_ARG   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_HND   = 3'd4;
    localparam logic [2:0] ST_DENIED    = 3'd5;
    localparam logic [2:0] ST_TYPE      = 3'd6;
    localparam logic [2:0] ST_INACTIVE  = 3'd7;

    localparam logic [31:0] REFS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ALU_INC = 2'd0,
        ALU_DEC = 2'd1,
        ALU_GEN = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic        y_zero;
        logic        a_zero;
        logic        a_max;
    } alu_flags_t;

    typedef struct packed {
        logic        active;
        logic [3:0]  otype;
        logic [31:0] refs;
        logic [63:0] value;
    } obj_entry_t;

    localparam int OBJ_W = $bits(obj_entry_t);

endpackage

[rtl/capability_handle_table.sv]
// Handle table over a pool of reference-counted objects. One transaction is
// taken at a time; in_stall stays high while it is worked on. Object and slot
// state sit in two memories with a registered read, so every table access
// has a read state and a check state, and one increment/decrement/generation
// unit is shared by all steps. Each operation passes idle, decode and done.
// Retain, release, open and revoke read the object; get, close and duplicate
// read the handle, and get and duplicate then the object. Create scans up to
// OBJECTS objects for a free one; open and duplicate scan up to HANDLES
// slots of the task or the peer; close all walks the task's slots and revoke
// all TASKS*HANDLES slots; close, close all and revoke release the object of
// each slot they close. A request rejected at decode goes straight to done,
// and a stalled result holds the block in done. After reset a clearing pass
// over max(TASKS*HANDLES, OBJECTS) addresses runs before the first
// transaction is taken; configuration writes are taken throughout.
module capability_handle_table
    import cht_pkg::*;
#(
    parameter int OBJECTS = 64,
    parameter int TASKS   = 16,
    parameter int HANDLES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [3:0]  task_id,
    input  logic        task_live,
    input  logic [3:0]  peer_task,
    input  logic        peer_live,
    input  logic [31:0] handle,
    input  logic [5:0]  object_id,
    input  logic [7:0]  rights,
    input  logic [3:0]  object_type,
    input  logic [63:0] object_value,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] handle_out,
    output logic [5:0]  object_out,
    output logic [63:0] value_out,
    output logic [9:0]  count_out,
    output logic        destroyed,
    output logic [6:0]  live_objects,
    output logic [9:0]  live_handles
);
`include "capability_handle_table_assert.svh"

    localparam int SLOTS  = TASKS * HANDLES;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW     = $clog2(OBJECTS);
    localparam int MAXN   = (SLOTS > OBJECTS) ? SLOTS : OBJECTS;
    localparam int CW     = $clog2(MAXN + 1);
    localparam int SLOT_W = 1 + 8 + 24 + OW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_C_RD, S_C_CHK, S_O_RD, S_O_CHK,
        S_S_RD, S_S_CHK, S_OS_RD, S_OS_CHK, S_SCAN_RD, S_SCAN_CHK,
        S_REL_RD, S_REL_CHK, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] base_reg, base_next;
    logic [SW-1:0] sidx_reg, sidx_next;
    logic [3:0]  op_reg, op_next;
    logic [3:0]  task_reg, task_next;
    logic        tlive_reg, tlive_next;
    logic [3:0]  peer_reg, peer_next;
    logic        plive_reg, plive_next;
    logic [31:0] hnd_reg, hnd_next;
    logic [5:0]  objid_reg, objid_next;
    logic [7:0]  rgt_reg, rgt_next;
    logic [3:0]  typ_reg, typ_next;
    logic [63:0] val_reg, val_next;
    logic [OW-1:0] tgt_reg, tgt_next;
    logic [OW-1:0] rel_reg, rel_next;
    obj_entry_t  oe_reg, oe_next;
    logic [2:0]  acc_status_reg, acc_status_next;
    logic [31:0] acc_hout_reg, acc_hout_next;
    logic [5:0]  acc_oout_reg, acc_oout_next;
    logic [63:0] acc_vout_reg, acc_vout_next;
    logic [9:0]  acc_count_reg, acc_count_next;
    logic        acc_dest_reg, acc_dest_next;
    logic [6:0]  oc_reg, oc_next;
    logic [9:0]  hc_reg, hc_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] hout_reg, hout_next;
    logic [5:0]  oout_reg, oout_next;
    logic [63:0] vout_reg, vout_next;
    logic [9:0]  count_reg, count_next;
    logic        dest_reg, dest_next;
    logic [6:0]  lobj_reg, lobj_next;
    logic [9:0]  lhnd_reg, lhnd_next;
    logic [7:0]  valid_rights_reg;
    logic [7:0]  transfer_right_reg;

    // memory ports
    logic              obj_we;
    logic [OW-1:0]     obj_waddr, obj_raddr;
    obj_entry_t        obj_wdata;
    logic [OBJ_W-1:0]  obj_rdata;
    obj_entry_t        o_rd;
    logic              slot_we;
    logic [SW-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_wdata, slot_rdata;

    // shared unit
    alu_op_t     alu_op;
    logic [31:0] alu_a, alu_y;
    alu_flags_t  alu_f;

    logic        s_used;
    logic [7:0]  s_rt;
    logic [23:0] s_gn;
    logic [OW-1:0] s_ob;
    logic        task_ok, obj_ok, in_acc;
    logic [7:0]  low;
    logic [CW-1:0] scan_end;

    cht_ram #(.WIDTH(OBJ_W), .DEPTH(OBJECTS)) u_obj_ram (
        .clk   (clk),
        .we    (obj_we),
        .waddr (obj_waddr),
        .wdata (obj_wdata),
        .raddr (obj_raddr),
        .rdata (obj_rdata)
    );

    cht_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    cht_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .y     (alu_y),
        .flags (alu_f)
    );

    assign o_rd   = obj_entry_t'(obj_rdata);
    assign s_used = slot_rdata[SLOT_W-1];
    assign s_rt   = slot_rdata[SLOT_W-2 -: 8];
    assign s_gn   = slot_rdata[SLOT_W-10 -: 24];
    assign s_ob   = slot_rdata[OW-1:0];

    assign task_ok  = tlive_reg && (32'(task_reg) < TASKS);
    assign obj_ok   = (32'(objid_reg) < OBJECTS);
    assign low      = hnd_reg[7:0];
    assign scan_end = (op_reg == OP_REVOKE) ? CW'(SLOTS - 1) : CW'(HANDLES - 1);
    assign in_acc   = in_valid && !in_stall;

    assign in_stall   = (state_reg != S_IDLE);
    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? {24'd0, transfer_right_reg} : {24'd0, valid_rights_reg};
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = hout_reg;
    assign object_out = oout_reg;
    assign value_out  = vout_reg;
    assign count_out  = count_reg;
    assign destroyed  = dest_reg;
    assign live_objects = lobj_reg;
    assign live_handles = lhnd_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_rights_reg   <= 8'd255;
            transfer_right_reg <= 8'd1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2])
            begin
                transfer_right_reg <= pwdata[7:0];
            end
            else
            begin
                valid_rights_reg <= pwdata[7:0];
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        base_next = base_reg;
        sidx_next = sidx_reg;
        op_next = op_reg;
        task_next = task_reg;
        tlive_next = tlive_reg;
        peer_next = peer_reg;
        plive_next = plive_reg;
        hnd_next = hnd_reg;
        objid_next = objid_reg;
        rgt_next = rgt_reg;
        typ_next = typ_reg;
        val_next = val_reg;
        tgt_next = tgt_reg;
        rel_next = rel_reg;
        oe_next = oe_reg;
        acc_status_next = acc_status_reg;
        acc_hout_next = acc_hout_reg;
        acc_oout_next = acc_oout_reg;
        acc_vout_next = acc_vout_reg;
        acc_count_next = acc_count_reg;
        acc_dest_next = acc_dest_reg;
        oc_next = oc_reg;
        hc_next = hc_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next = status_reg;
        hout_next = hout_reg;
        oout_next = oout_reg;
        vout_next = vout_reg;
        count_next = count_reg;
        dest_next = dest_reg;
        lobj_next = lobj_reg;
        lhnd_next = lhnd_reg;

        obj_we = 1'b0;
        obj_waddr = tgt_reg;
        obj_wdata = o_rd;
        obj_raddr = tgt_reg;
        slot_we = 1'b0;
        slot_waddr = sidx_reg;
        slot_wdata = {1'b0, 8'd0, alu_y[23:0], s_ob};
        slot_raddr = base_reg + SW'(idx_reg);

        alu_op = ALU_INC;
        alu_a = o_rd.refs;

        unique case (state_reg)
            // sweep both memories to their reset contents
            S_CLEAR:
            begin
                slot_we = (32'(idx_reg) < SLOTS);
                slot_waddr = SW'(idx_reg);
                slot_wdata = {1'b0, 8'd0, 24'd1, {OW{1'b0}}};
                obj_we = (32'(idx_reg) < OBJECTS);
                obj_waddr = OW'(idx_reg);
                obj_wdata = '0;
                if (idx_reg == CW'(MAXN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = opcode;
                    task_next = task_id;
                    tlive_next = task_live;
                    peer_next = peer_task;
                    plive_next = peer_live;
                    hnd_next = handle;
                    objid_next = object_id;
                    rgt_next = rights;
                    typ_next = object_type;
                    val_next = object_value;
                    acc_status_next = ST_OK;
                    acc_hout_next = 32'd0;
                    acc_oout_next = 6'd0;
                    acc_vout_next = 64'd0;
                    acc_count_next = 10'd0;
                    acc_dest_next = 1'b0;
                    state_next = S_DECODE;
                end
            end

            // early argument checks and first address
            S_DECODE:
            begin
                idx_next = '0;
                tgt_next = OW'(objid_reg);
                state_next = S_DONE;
                unique case (op_reg) inside
                    OP_CREATE:
                    begin
                        if (typ_reg == 4'd0)
                        begin
                            acc_status_next = ST_BAD_ARG;
                        end
                        else
                        begin
                            state_next = S_C_RD;
                        end
                    end
                    OP_RETAIN, OP_RELEASE, OP_REVOKE:
                    begin
                        if (!obj_ok)
                        begin
                            acc_status_next = ST_BAD_ARG;
                        end
                        else
                        begin
                            state_next = S_O_RD;
                        end
                    end
                    OP_OPEN:
                    begin
                        base_next = SW'(32'(task_reg) * HANDLES);
                        if (!task_ok)
                        begin
                            acc_status_next = ST_BAD_TASK;
                        end
                        else if (!obj_ok)
                        begin
                            acc_status_next = ST_BAD_ARG;
                        end
                        else
                        begin
                            state_next = S_O_RD;
                        end
                    end
                    OP_GET, OP_CLOSE, OP_DUPLICATE:
                    begin
                        sidx_next = SW'(32'(task_reg) * HANDLES + 32'(low) - 32'd1);
                        if (!task_ok)
                        begin
                            acc_status_next = ST_BAD_TASK;
                        end
                        else if (low == 8'd0 || 32'(low) > HANDLES)
                        begin
                            acc_status_next = ST_BAD_HND;
                        end
                        else
                        begin
                            state_next = S_S_RD;
                        end
                    end
                    OP_CLOSE_ALL:
                    begin
                        base_next = SW'(32'(task_reg) * HANDLES);
                        if (!task_ok)
                        begin
                            acc_status_next = ST_BAD_TASK;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        acc_status_next = ST_BAD_ARG;
                    end
                endcase
            end

            // create: look for a free object
            S_C_RD:
            begin
                obj_raddr = OW'(idx_reg);
                state_next = S_C_CHK;
            end

            S_C_CHK:
            begin
                if (!o_rd.active)
                begin
                    obj_we = 1'b1;
                    obj_waddr = OW'(idx_reg);
                    obj_wdata = '{active: 1'b1, otype: typ_reg, refs: 32'd1, value: val_reg};
                    oc_next = oc_reg + 7'd1;
                    acc_oout_next = 6'(idx_reg);
                    state_next = S_DONE;
                end
                else if (idx_reg == CW'(OBJECTS - 1))
                begin
                    acc_status_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_C_RD;
                end
            end

            S_O_RD:
            begin
                obj_raddr = tgt_reg;
                state_next = S_O_CHK;
            end

            // object checks per operation
            S_O_CHK:
            begin
                oe_next = o_rd;
                state_next = S_DONE;
                alu_op = (op_reg == OP_RELEASE) ? ALU_DEC : ALU_INC;
                obj_wdata = o_rd;
                obj_wdata.refs = alu_y;
                unique case (op_reg) inside
                    OP_RETAIN:
                    begin
                        if (!o_rd.active || alu_f.a_zero || alu_f.a_max)
                        begin
                            acc_status_next = ST_INACTIVE;
                        end
                        else
                        begin
                            obj_we = 1'b1;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (!o_rd.active || alu_f.a_zero)
                        begin
                            acc_status_next = ST_INACTIVE;
                        end
                        else
                        begin
                            obj_we = 1'b1;
                            if (alu_f.y_zero)
                            begin
                                obj_wdata = '0;
                                oc_next = oc_reg - 7'd1;
                                acc_dest_next = 1'b1;
                            end
                        end
                    end
                    OP_REVOKE:
                    begin
                        if (!o_rd.active)
                        begin
                            acc_status_next = ST_INACTIVE;
                        end
                        else
                        begin
                            base_next = '0;
                            idx_next = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_OPEN, OP_DUPLICATE:
                    begin
                        if (!o_rd.active)
                        begin
                            acc_status_next = ST_INACTIVE;
                        end
                        else if (rgt_reg == 8'd0 || (rgt_reg & ~valid_rights_reg) != 8'd0)
                        begin
                            acc_status_next = ST_BAD_ARG;
                        end
                        else
                        begin
                            idx_next = '0;
                            state_next = S_OS_RD;
                        end
                    end
                    OP_GET:
                    begin
                        if (typ_reg != 4'd0 && o_rd.otype != typ_reg)
                        begin
                            acc_status_next = ST_TYPE;
                        end
                        else
                        begin
                            acc_oout_next = 6'(tgt_reg);
                            acc_vout_next = o_rd.value;
                        end
                    end
                    default:
                    begin
                        acc_status_next = ST_BAD_ARG;
                    end
                endcase
            end

            // handle lookup
            S_S_RD:
            begin
                slot_raddr = sidx_reg;
                state_next = S_S_CHK;
            end

            S_S_CHK:
            begin
                alu_op = ALU_GEN;
                alu_a = {8'd0, s_gn};
                tgt_next = s_ob;
                rel_next = s_ob;
                state_next = S_DONE;
                if (!s_used || s_gn != hnd_reg[31:8])
                begin
                    acc_status_next = ST_BAD_HND;
                end
                else
                begin
                    unique case (op_reg)
                        OP_GET:
                        begin
                            if ((rgt_reg & ~s_rt) != 8'd0)
                            begin
                                acc_status_next = ST_DENIED;
                            end
                            else
                            begin
                                state_next = S_O_RD;
                            end
                        end
                        OP_CLOSE:
                        begin
                            slot_we = 1'b1;
                            hc_next = hc_reg - 10'd1;
                            state_next = S_REL_RD;
                        end
                        OP_DUPLICATE:
                        begin
                            base_next = SW'(32'(peer_reg) * HANDLES);
                            if ((s_rt & transfer_right_reg) == 8'd0)
                            begin
                                acc_status_next = ST_DENIED;
                            end
                            else if (rgt_reg == 8'd0)
                            begin
                                acc_status_next = ST_BAD_ARG;
                            end
                            else if ((rgt_reg & ~s_rt) != 8'd0)
                            begin
                                acc_status_next = ST_DENIED;
                            end
                            else if (!plive_reg || 32'(peer_reg) >= TASKS)
                            begin
                                acc_status_next = ST_BAD_TASK;
                            end
                            else
                            begin
                                state_next = S_O_RD;
                            end
                        end
                        default:
                        begin
                            acc_status_next = ST_BAD_ARG;
                        end
                    endcase
                end
            end

            // open: look for a free slot of the task
            S_OS_RD:
            begin
                sidx_next = slot_raddr;
                state_next = S_OS_CHK;
            end

            S_OS_CHK:
            begin
                alu_a = oe_reg.refs;
                if (!s_used)
                begin
                    state_next = S_DONE;
                    if (alu_f.a_zero || alu_f.a_max)
                    begin
                        acc_status_next = ST_INACTIVE;
                    end
                    else
                    begin
                        obj_we = 1'b1;
                        obj_wdata = oe_reg;
                        obj_wdata.refs = alu_y;
                        slot_we = 1'b1;
                        slot_wdata = {1'b1, rgt_reg, s_gn, tgt_reg};
                        hc_next = hc_reg + 10'd1;
                        acc_hout_next = {s_gn, 8'(idx_reg + CW'(1))};
                    end
                end
                else if (idx_reg == CW'(HANDLES - 1))
                begin
                    acc_status_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_OS_RD;
                end
            end

            // revoke and close all: walk slots
            S_SCAN_RD:
            begin
                sidx_next = slot_raddr;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                alu_op = ALU_GEN;
                alu_a = {8'd0, s_gn};
                rel_next = s_ob;
                if (s_used && (op_reg != OP_REVOKE || s_ob == tgt_reg))
                begin
                    slot_we = 1'b1;
                    hc_next = hc_reg - 10'd1;
                    acc_count_next = acc_count_reg + 10'd1;
                    state_next = S_REL_RD;
                end
                else if (idx_reg == scan_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            // release the object of a dropped slot
            S_REL_RD:
            begin
                obj_raddr = rel_reg;
                state_next = S_REL_CHK;
            end

            S_REL_CHK:
            begin
                alu_op = ALU_DEC;
                obj_waddr = rel_reg;
                obj_wdata = o_rd;
                obj_wdata.refs = alu_y;
                if (o_rd.active && !alu_f.a_zero)
                begin
                    obj_we = 1'b1;
                    if (alu_f.y_zero)
                    begin
                        obj_wdata = '0;
                        oc_next = oc_reg - 7'd1;
                        acc_dest_next = 1'b1;
                    end
                end
                if (op_reg == OP_CLOSE || idx_reg == scan_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next = acc_status_reg;
                    hout_next = (acc_status_reg == ST_OK) ? acc_hout_reg : 32'd0;
                    oout_next = acc_oout_reg;
                    vout_next = acc_vout_reg;
                    count_next = acc_count_reg;
                    dest_next = acc_dest_reg;
                    lobj_next = oc_reg;
                    lhnd_next = hc_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            base_reg <= '0;
            sidx_reg <= '0;
            op_reg <= 4'd0;
            task_reg <= 4'd0;
            tlive_reg <= 1'b0;
            peer_reg <= 4'd0;
            plive_reg <= 1'b0;
            hnd_reg <= 32'd0;
            objid_reg <= 6'd0;
            rgt_reg <= 8'd0;
            typ_reg <= 4'd0;
            val_reg <= 64'd0;
            tgt_reg <= '0;
            rel_reg <= '0;
            oe_reg <= '0;
            acc_status_reg <= ST_OK;
            acc_hout_reg <= 32'd0;
            acc_oout_reg <= 6'd0;
            acc_vout_reg <= 64'd0;
            acc_count_reg <= 10'd0;
            acc_dest_reg <= 1'b0;
            oc_reg <= 7'd0;
            hc_reg <= 10'd0;
            out_valid_reg <= 1'b0;
            status_reg <= ST_OK;
            hout_reg <= 32'd0;
            oout_reg <= 6'd0;
            vout_reg <= 64'd0;
            count_reg <= 10'd0;
            dest_reg <= 1'b0;
            lobj_reg <= 7'd0;
            lhnd_reg <= 10'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            base_reg <= base_next;
            sidx_reg <= sidx_next;
            op_reg <= op_next;
            task_reg <= task_next;
            tlive_reg <= tlive_next;
            peer_reg <= peer_next;
            plive_reg <= plive_next;
            hnd_reg <= hnd_next;
            objid_reg <= objid_next;
            rgt_reg <= rgt_next;
            typ_reg <= typ_next;
            val_reg <= val_next;
            tgt_reg <= tgt_next;
            rel_reg <= rel_next;
            oe_reg <= oe_next;
            acc_status_reg <= acc_status_next;
            acc_hout_reg <= acc_hout_next;
            acc_oout_reg <= acc_oout_next;
            acc_vout_reg <= acc_vout_next;
            acc_count_reg <= acc_count_next;
            acc_dest_reg <= acc_dest_next;
            oc_reg <= oc_next;
            hc_reg <= hc_next;
            out_valid_reg <= out_valid_next;
            status_reg <= status_next;
            hout_reg <= hout_next;
            oout_reg <= oout_next;
            vout_reg <= vout_next;
            count_reg <= count_next;
            dest_reg <= dest_next;
            lobj_reg <= lobj_next;
            lhnd_reg <= lhnd_next;
        end
    end

    `CHT_ASSERT_NEXT(a_accept_decode, in_acc, state_reg == S_DECODE, "accepted transaction not decoded")
    `CHT_ASSERT(a_result_from_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result raised outside done")
    `CHT_ASSERT(a_hc_step, $stable(hc_reg) || hc_reg == $past(hc_reg) + 10'd1 || hc_reg == $past(hc_reg) - 10'd1, "handle count jumped")
endmodule

[rtl/cht_ram.sv]
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/cht_alu.sv]
module cht_alu
    import cht_pkg::*;
(
    input  alu_op_t     op,
    input  logic [31:0] a,
    output logic [31:0] y,
    output alu_flags_t  flags
);
    logic [23:0] gen_inc;

    // increment, decrement, or generation bump that skips zero
    always_comb
    begin
        gen_inc = a[23:0] + 24'd1;
        case (op)
            ALU_INC: y = a + 32'd1;
            ALU_DEC: y = a - 32'd1;
            ALU_GEN: y = (gen_inc == 24'd0) ? 32'd1 : {8'd0, gen_inc};
            default: y = a;
        endcase
        flags.y_zero = (y == 32'd0);
        flags.a_zero = (a == 32'd0);
        flags.a_max  = (a == REFS_MAX);
    end
endmodule
